### src/maf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants and types for the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_MAX  = 64;
    localparam int LEN_BITS    = 7;
    localparam int SLOT_BITS   = 6;
    localparam int SUM_BITS    = 23;
    localparam int MAG_BITS    = 22;
    localparam int ITER_BITS   = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_BITS-1:0] WINDOW_RESET = LEN_BITS'(8);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [LEN_BITS-1:0]           len_t;

    // Request from the accumulator to the divider.
    typedef struct packed {
        logic start;
        sum_t sum;
        len_t len;
    } div_req_t;

    function automatic len_t effective_len(input len_t raw);
        len_t res;
        if (raw == '0) begin
            res = LEN_BITS'(1);
        end else if (raw > LEN_BITS'(WINDOW_MAX)) begin
            res = LEN_BITS'(WINDOW_MAX);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/maf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maf_queue
// Two-entry sample queue that decouples the input channel from the
// accumulator.
// ----------------------------------------------------------------------------
module maf_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire maf_pkg::sample_t s_sample,
    output logic                q_valid,
    output maf_pkg::sample_t    q_sample,
    input  wire                 q_pop
);

    maf_pkg::sample_t mem_reg [maf_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign s_ready  = (count_reg != 2'(maf_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_sample = mem_reg[rd_ptr_reg];
    assign push     = s_valid && s_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_sample;
        end
    end

endmodule
`default_nettype wire

### src/maf_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maf_accum
// Sample ring and running sum. Each sample is added to the window, replacing the
// oldest one once it is full, and a division request is issued whenever the window is full.
// ----------------------------------------------------------------------------
module maf_accum (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   restart,
    input  wire maf_pkg::len_t    len,
    input  wire                   q_valid,
    input  wire maf_pkg::sample_t q_sample,
    output logic                  q_pop,
    input  wire                   div_ready,
    output maf_pkg::div_req_t     div_req
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    maf_pkg::sample_t ring_mem [maf_pkg::WINDOW_MAX];

    logic                               state_reg, state_next;
    maf_pkg::sum_t                      sum_reg, sum_next;
    logic [maf_pkg::LEN_BITS-1:0]       fill_reg, fill_next;
    logic [maf_pkg::SLOT_BITS-1:0]      wslot_reg, wslot_next;
    logic [maf_pkg::SLOT_BITS-1:0]      cur_slot_reg, cur_slot_next;
    maf_pkg::sample_t                   x_reg, x_next;
    maf_pkg::sample_t                   old_reg;
    logic [maf_pkg::SLOT_BITS-1:0]      slot_sel;
    logic [maf_pkg::LEN_BITS-1:0]       slot_inc;
    logic                               full;
    logic                               take;
    maf_pkg::sum_t                      sum_sub;

    assign slot_sel = ({1'b0, wslot_reg} >= len) ? '0 : wslot_reg;
    assign slot_inc = {1'b0, cur_slot_reg} + maf_pkg::LEN_BITS'(1);
    assign full     = (fill_reg >= len);
    assign take     = (state_reg == ST_IDLE) && q_valid && div_ready;
    assign q_pop    = take;
    assign sum_sub  = full ? (sum_reg - maf_pkg::sum_t'(old_reg)) : sum_reg;

    always_comb begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        fill_next     = fill_reg;
        wslot_next    = wslot_reg;
        cur_slot_next = cur_slot_reg;
        x_next        = x_reg;
        div_req.start = 1'b0;
        div_req.sum   = '0;
        div_req.len   = len;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    x_next        = q_sample;
                    cur_slot_next = slot_sel;
                    state_next    = ST_UPD;
                end
            end
            ST_UPD: begin
                sum_next   = sum_sub + maf_pkg::sum_t'(x_reg);
                fill_next  = full ? len : fill_reg + maf_pkg::LEN_BITS'(1);
                wslot_next = (slot_inc >= len) ? '0 : slot_inc[maf_pkg::SLOT_BITS-1:0];
                div_req.start = (fill_next >= len);
                div_req.sum   = sum_next;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (restart) begin
            sum_next   = '0;
            fill_next  = '0;
            wslot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            fill_reg  <= '0;
            wslot_reg <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            wslot_reg <= wslot_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_slot_reg <= cur_slot_next;
        x_reg        <= x_next;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            old_reg <= ring_mem[slot_sel];
        end
        if (state_reg == ST_UPD) begin
            ring_mem[cur_slot_reg] <= x_reg;
        end
    end

endmodule
`default_nettype wire

### src/maf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maf_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero,
// with an output register on the result channel.
// ----------------------------------------------------------------------------
module maf_div (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire maf_pkg::div_req_t div_req,
    output logic                   div_ready,
    output logic                   m_valid,
    input  wire                    m_ready,
    output maf_pkg::sample_t       m_mean
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [maf_pkg::ITER_BITS-1:0]   cnt_reg, cnt_next;
    logic [maf_pkg::MAG_BITS-1:0]    quo_reg, quo_next;
    logic [maf_pkg::LEN_BITS-1:0]    rem_reg, rem_next;
    logic [maf_pkg::LEN_BITS-1:0]    den_reg, den_next;
    logic                            neg_reg, neg_next;
    logic                            out_valid_reg, out_valid_next;
    maf_pkg::sample_t                mean_reg, mean_next;
    maf_pkg::sum_t                   sum_abs;
    logic [maf_pkg::LEN_BITS:0]      rem_sh;
    logic [maf_pkg::LEN_BITS:0]      rem_diff;
    logic                            ge;
    logic [maf_pkg::MAG_BITS-1:0]    quo_signed;

    assign div_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_mean    = mean_reg;

    assign sum_abs    = div_req.sum[maf_pkg::SUM_BITS-1] ? -div_req.sum : div_req.sum;
    assign rem_sh     = {rem_reg, quo_reg[maf_pkg::MAG_BITS-1]};
    assign rem_diff   = rem_sh - {1'b0, den_reg};
    assign ge         = (rem_sh >= {1'b0, den_reg});
    assign quo_signed = neg_reg ? -quo_reg : quo_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (div_req.start) begin
                    quo_next   = sum_abs[maf_pkg::MAG_BITS-1:0];
                    rem_next   = '0;
                    den_next   = div_req.len;
                    neg_next   = div_req.sum[maf_pkg::SUM_BITS-1];
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                quo_next = {quo_reg[maf_pkg::MAG_BITS-2:0], ge};
                rem_next = ge ? rem_diff[maf_pkg::LEN_BITS-1:0]
                              : rem_sh[maf_pkg::LEN_BITS-1:0];
                cnt_next = cnt_reg + maf_pkg::ITER_BITS'(1);
                if (cnt_reg == maf_pkg::ITER_BITS'(maf_pkg::MAG_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    mean_next      = quo_signed[maf_pkg::SAMPLE_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

endmodule
`default_nettype wire

### src/moving_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_filter
// Simple moving average of signed 16-bit samples over a configurable window.
//
// Samples arrive as valid/ready transactions on the s_ channel. From the sample
// that fills the window to window_len samples on, each sample produces one mean
// transaction on the m_ channel; the samples before it produce none.
// A window length of zero acts as one and lengths above 64 act as 64. Writing
// cfg_wr_data with cfg_wr_en restarts the window; the user must do this only
// while idle, as the block does not enforce it. A sample enters a two-entry
// queue; the accumulator takes it when the divider is free. The serial divider
// produces one quotient bit per cycle over 22 bits. A stalled receiver holds
// the mean in the output register while the divider and the queue go on; once
// both are full, s_ready falls.
// After reset the window length is 8 and the window is empty.
// ----------------------------------------------------------------------------
module moving_average_filter (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_wr_en,
    input  wire maf_pkg::len_t    cfg_wr_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire maf_pkg::sample_t s_sample,
    output logic                  m_valid,
    input  wire                   m_ready,
    output maf_pkg::sample_t      m_mean
);

    maf_pkg::len_t     window_len_reg;
    maf_pkg::len_t     len_eff;
    logic              q_valid;
    maf_pkg::sample_t  q_sample;
    logic              q_pop;
    logic              div_ready;
    maf_pkg::div_req_t div_req;

    assign len_eff = maf_pkg::effective_len(window_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= maf_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_len_reg <= cfg_wr_data;
        end
    end

    maf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_valid  (q_valid),
        .q_sample (q_sample),
        .q_pop    (q_pop)
    );

    maf_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (cfg_wr_en),
        .len       (len_eff),
        .q_valid   (q_valid),
        .q_sample  (q_sample),
        .q_pop     (q_pop),
        .div_ready (div_ready),
        .div_req   (div_req)
    );

    maf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_req   (div_req),
        .div_ready (div_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mean    (m_mean)
    );

endmodule
`default_nettype wire

### tb/sv/tb_moving_average_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Self-checking testbench for the moving average filter.
//
// A clocked driver sends samples from a queue that the stimulus process fills
// phase by phase. Each accepted sample goes through a behavioural copy of the
// sliding window, which queues the mean that the block should return. A
// clocked monitor compares every mean transaction with the oldest queued
// value. The window length is changed between phases, once the block is idle,
// to cover zero, one, the maximum, values above the maximum, a restart before
// the window has filled and a rewrite of the same length. Both sides insert
// random gaps, with some phases that run without any.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    localparam int               RANDOM_TARGET  = 800;
    localparam int               SETTLE_CYCLES  = 64;
    localparam int               WATCHDOG_LIMIT = 2000;
    localparam maf_pkg::sample_t SAMPLE_MAX     = 16'sh7fff;
    localparam maf_pkg::sample_t SAMPLE_MIN     = 16'sh8000;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    maf_pkg::len_t    cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    maf_pkg::sample_t s_sample    = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    maf_pkg::sample_t m_mean;

    maf_pkg::sample_t pending_samples[$];
    maf_pkg::sample_t expected_means[$];

    maf_pkg::len_t window_len_reg = maf_pkg::WINDOW_RESET;
    int   window_ring[maf_pkg::WINDOW_MAX];
    int   window_sum     = 0;
    int   window_held    = 0;
    int   window_slot    = 0;

    bit   steady        = 1'b0;
    int   send_gap      = 0;
    int   stall_left    = 0;
    int   quiet_cycles  = 0;
    int   samples_sent  = 0;
    int   means_checked = 0;
    int   windows_set   = 0;
    int   fail_count    = 0;

    moving_average_filter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mean      (m_mean)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_window(input maf_pkg::len_t raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > maf_pkg::WINDOW_MAX) begin
            return maf_pkg::WINDOW_MAX;
        end
        return int'(raw);
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 70) begin
            return 0;
        end else if (pick < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Adds one sample to the window and queues the mean once the window is full.
    task automatic predict_window_mean(input maf_pkg::sample_t x);
        int n;
        int slot;
        n    = clamp_window(window_len_reg);
        slot = window_slot;
        if (slot >= n) begin
            slot = 0;
        end
        if (window_held >= n) begin
            window_sum -= window_ring[slot];
            window_held = n;
        end else begin
            window_held++;
        end
        window_sum += int'(x);
        window_ring[slot] = int'(x);
        slot++;
        if (slot >= n) begin
            slot = 0;
        end
        window_slot = slot;
        if (window_held >= n) begin
            expected_means.push_back(maf_pkg::sample_t'(window_sum / n));
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_means.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_window_mean(s_sample);
                samples_sent++;
                send_gap = pick_gap();
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_valid  <= 1'b1;
                s_sample <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin : mean_check
        maf_pkg::sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_means.size() == 0) begin
                $error("mean: expected nothing, actual %0d", m_mean);
                fail_count++;
            end else begin
                want = expected_means.pop_front();
                means_checked++;
                if (m_mean !== want) begin
                    $error("mean: expected %0d, actual %0d", want, m_mean);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        maf_pkg::len_t    fixed_lens[9];
        maf_pkg::len_t    next_len;
        maf_pkg::sample_t item_value;
        int               random_sent;
        int               n_items;
        int               phase;
        int               pick;
        int               i;
        bit               extreme_run;
        bit               bias_pos;

        fixed_lens = '{7'd127, 7'd0, 7'd1, 7'd127, 7'd64, 7'd65, 7'd2, 7'd3, 7'd3};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset window of eight: full-scale runs of both signs, then small values
        // whose sums must be truncated towards zero.
        for (i = 0; i < 8; i++) begin
            pending_samples.push_back(SAMPLE_MAX);
        end
        for (i = 0; i < 8; i++) begin
            pending_samples.push_back(SAMPLE_MIN);
        end
        pending_samples.push_back(maf_pkg::sample_t'(-1));
        pending_samples.push_back(maf_pkg::sample_t'(1));
        pending_samples.push_back(maf_pkg::sample_t'(-3));
        pending_samples.push_back(maf_pkg::sample_t'(0));
        pending_samples.push_back(maf_pkg::sample_t'(5));
        pending_samples.push_back(maf_pkg::sample_t'(-7));
        wait_idle();

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_TARGET) begin
            next_len = (phase < 9) ? fixed_lens[phase]
                                   : maf_pkg::len_t'($urandom_range(0, 127));

            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= next_len;
            window_len_reg = next_len;
            window_sum     = 0;
            window_held    = 0;
            window_slot    = 0;
            windows_set++;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(negedge aclk);

            // The first phase stops short of a full window, so the next write
            // restarts a partly filled one.
            n_items     = (phase == 0) ? 30 : clamp_window(next_len) + $urandom_range(20, 60);
            extreme_run = ($urandom_range(0, 3) == 0);
            bias_pos    = $urandom_range(0, 1);
            steady      = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n_items; i++) begin
                pick = $urandom_range(0, 99);
                if (extreme_run && pick < 80) begin
                    item_value = bias_pos ? SAMPLE_MAX : SAMPLE_MIN;
                end else if (pick < 5) begin
                    item_value = SAMPLE_MAX;
                end else if (pick < 10) begin
                    item_value = SAMPLE_MIN;
                end else if (pick < 25) begin
                    item_value = maf_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
                end else begin
                    item_value = maf_pkg::sample_t'($urandom());
                end
                pending_samples.push_back(item_value);
            end
            random_sent += n_items;
            wait_idle();
            phase++;
        end

        $display("Sent %0d samples over %0d window length settings after the reset window,",
                 samples_sent, windows_set);
        $display("and compared %0d mean transactions.", means_checked);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
